[hdl/dlr_pkg.sv]
// Shared types and constants of the line rasterizer with bit-plane frame store.
package dlr_pkg;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned COORD_W   = 9;
  localparam int unsigned COL_IDX_W = 7;
  localparam int unsigned WORD_W    = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 3'd0,
    CMD_PIXEL = 3'd1,
    CMD_LINE  = 3'd2,
    CMD_WRCOL = 3'd3,
    CMD_RDCOL = 3'd4
  } cmd_e;

endpackage

[hdl/dlr_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module dlr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/dda_line_raster_bitplane.sv]
// Top level: bit-plane frame store in RAM with a DDA line rasterizer on top.
// One request at a time. Clear: a zeroing sweep over every column.
// Put pixel: one RAM read-modify-write, or none if off screen. Draw line: a
// restoring divider forms the x and then the y increment, then each on-screen
// pixel takes one RAM read-modify-write and each clipped pixel is skipped; at
// most 511 steps, no more than 128 of them on screen. Write column: one RAM
// write; read column: registered RAM read. After reset a zeroing sweep runs.
module dda_line_raster_bitplane #(
  parameter int unsigned COLUMNS   = 128,
  parameter int unsigned ROWS      = 32,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [dlr_pkg::CMD_W-1:0]             command_i,
  input  logic signed [dlr_pkg::COORD_W-1:0]    x_start_i,
  input  logic signed [dlr_pkg::COORD_W-1:0]    y_start_i,
  input  logic signed [dlr_pkg::COORD_W-1:0]    x_end_i,
  input  logic signed [dlr_pkg::COORD_W-1:0]    y_end_i,
  input  logic [dlr_pkg::COL_IDX_W-1:0]         column_index_i,
  input  logic [dlr_pkg::WORD_W-1:0]            column_bits_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [dlr_pkg::WORD_W-1:0]            read_bits_o,
  output logic                                  clipped_o
);

  localparam int unsigned CW  = $clog2(COLUMNS);
  localparam int unsigned RW  = $clog2(ROWS);
  localparam int unsigned SW  = dlr_pkg::COORD_W;
  localparam int unsigned PW  = 12;
  localparam int unsigned AW  = PW + FRAC_BITS;
  localparam int unsigned NW  = SW + FRAC_BITS;
  localparam int unsigned DCW = $clog2(NW + 1);

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIVX  = 3'd2;
  localparam logic [2:0] S_DIVY  = 3'd3;
  localparam logic [2:0] S_PLOT  = 3'd4;
  localparam logic [2:0] S_MOD   = 3'd5;
  localparam logic [2:0] S_RDCOL = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [PW-1:0] COLS_P = PW'(COLUMNS);
  localparam logic [PW-1:0] ROWS_P = PW'(ROWS);

  logic [2:0]                 state_q, state_d;
  logic                       sweep_clr_q, sweep_clr_d;
  logic [CW-1:0]              sw_q, sw_d;
  logic [AW-1:0]              px_q, px_d, py_q, py_d, ax_q, ax_d, ay_q, ay_d;
  logic [SW-1:0]              cnt_q, cnt_d, steps_q, steps_d, ady_q, ady_d;
  logic                       sx_q, sx_d, sy_q, sy_d;
  logic [NW-1:0]              num_q, num_d;
  logic [SW-1:0]              rem_q, rem_d;
  logic [DCW-1:0]             dcnt_q, dcnt_d;
  logic [CW-1:0]              pix_addr_q, pix_addr_d;
  logic [RW-1:0]              pix_row_q, pix_row_d;
  logic [dlr_pkg::WORD_W-1:0] res_bits_q, res_bits_d;
  logic                       res_clip_q, res_clip_d;
  logic                       out_valid_q, out_valid_d;
  logic [dlr_pkg::WORD_W-1:0] out_bits_q, out_bits_d;
  logic                       out_clip_q, out_clip_d;

  logic                ram_we, ram_re;
  logic [CW-1:0]       ram_waddr, ram_raddr;
  logic [ROWS-1:0]     ram_wdata, ram_rdata;

  logic                in_fire;
  logic [SW:0]         dx, dy;
  logic [SW-1:0]       adx, ady, steps;
  logic [15:0]         col_ext;
  logic                col_ok;
  logic [63:0]         wr_ext, rd_ext;
  logic [PW-1:0]       pix_x, pix_y;
  logic                on_screen;
  logic [SW:0]         rem_sh, rem_nx;
  logic                q_bit;
  logic [NW-1:0]       q_nx;
  logic [AW-1:0]       q_ext;
  logic                div_last;

  dlr_ram #(
    .WIDTH (ROWS),
    .DEPTH (COLUMNS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Line setup: deltas, magnitudes and step count.
  assign dx    = {x_end_i[SW-1], x_end_i} - {x_start_i[SW-1], x_start_i};
  assign dy    = {y_end_i[SW-1], y_end_i} - {y_start_i[SW-1], y_start_i};
  assign adx   = dx[SW] ? SW'(-dx) : dx[SW-1:0];
  assign ady   = dy[SW] ? SW'(-dy) : dy[SW-1:0];
  assign steps = (adx > ady) ? adx : ady;

  assign col_ext = 16'(column_index_i);
  assign col_ok  = col_ext < 16'(COLUMNS);
  assign wr_ext  = 64'(column_bits_i);
  assign rd_ext  = 64'(ram_rdata);

  // Integer part of the accumulators is the floor of the fixed-point value.
  assign pix_x     = px_q[AW-1:FRAC_BITS];
  assign pix_y     = py_q[AW-1:FRAC_BITS];
  assign on_screen = !pix_x[PW-1] && (pix_x < COLS_P) && !pix_y[PW-1] && (pix_y < ROWS_P);

  // One restoring division step per cycle.
  assign rem_sh   = {rem_q, num_q[NW-1]};
  assign q_bit    = rem_sh >= {1'b0, steps_q};
  assign rem_nx   = q_bit ? (rem_sh - {1'b0, steps_q}) : rem_sh;
  assign q_nx     = {num_q[NW-2:0], q_bit};
  assign q_ext    = AW'(q_nx);
  assign div_last = (dcnt_q == DCW'(NW - 1));

  always_comb begin
    state_d     = state_q;
    sweep_clr_d = sweep_clr_q;
    sw_d        = sw_q;
    px_d        = px_q;
    py_d        = py_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    cnt_d       = cnt_q;
    steps_d     = steps_q;
    ady_d       = ady_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    num_d       = num_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    pix_addr_d  = pix_addr_q;
    pix_row_d   = pix_row_q;
    res_bits_d  = res_bits_q;
    res_clip_d  = res_clip_q;
    out_valid_d = out_valid_q;
    out_bits_d  = out_bits_q;
    out_clip_d  = out_clip_q;
    ram_we      = 1'b0;
    ram_waddr   = pix_addr_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = pix_x[CW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sw_q;
        sw_d      = sw_q + CW'(1);
        if (sw_q == CW'(COLUMNS - 1)) begin
          sw_d    = '0;
          state_d = sweep_clr_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          res_bits_d  = '0;
          res_clip_d  = 1'b0;
          sweep_clr_d = 1'b0;
          px_d = {{(PW-SW){x_start_i[SW-1]}}, x_start_i, {FRAC_BITS{1'b0}}};
          py_d = {{(PW-SW){y_start_i[SW-1]}}, y_start_i, {FRAC_BITS{1'b0}}};
          unique case (dlr_pkg::cmd_e'(command_i))
            dlr_pkg::CMD_CLEAR: begin
              sweep_clr_d = 1'b1;
              state_d     = S_SWEEP;
            end
            dlr_pkg::CMD_PIXEL: begin
              ax_d    = '0;
              ay_d    = '0;
              cnt_d   = SW'(1);
              state_d = S_PLOT;
            end
            dlr_pkg::CMD_LINE: begin
              steps_d = steps;
              ady_d   = ady;
              sx_d    = dx[SW];
              sy_d    = dy[SW];
              cnt_d   = steps;
              num_d   = {adx, {FRAC_BITS{1'b0}}};
              rem_d   = '0;
              dcnt_d  = '0;
              state_d = (steps == '0) ? S_DONE : S_DIVX;
            end
            dlr_pkg::CMD_WRCOL: begin
              ram_we     = col_ok;
              ram_waddr  = col_ext[CW-1:0];
              ram_wdata  = wr_ext[ROWS-1:0];
              res_clip_d = !col_ok;
              state_d    = S_DONE;
            end
            dlr_pkg::CMD_RDCOL: begin
              ram_re     = col_ok;
              ram_raddr  = col_ext[CW-1:0];
              res_clip_d = !col_ok;
              state_d    = col_ok ? S_RDCOL : S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_DIVX, S_DIVY: begin
        rem_d  = rem_nx[SW-1:0];
        num_d  = q_nx;
        dcnt_d = dcnt_q + DCW'(1);
        if (div_last) begin
          rem_d  = '0;
          dcnt_d = '0;
          if (state_q == S_DIVX) begin
            ax_d    = sx_q ? AW'(-q_ext) : q_ext;
            num_d   = {ady_q, {FRAC_BITS{1'b0}}};
            state_d = S_DIVY;
          end else begin
            ay_d    = sy_q ? AW'(-q_ext) : q_ext;
            state_d = S_PLOT;
          end
        end
      end
      S_PLOT: begin
        if (on_screen) begin
          ram_re     = 1'b1;
          pix_addr_d = pix_x[CW-1:0];
          pix_row_d  = pix_y[RW-1:0];
          state_d    = S_MOD;
        end else begin
          // skip the pixel and advance
          res_clip_d = 1'b1;
          px_d       = px_q + ax_q;
          py_d       = py_q + ay_q;
          cnt_d      = cnt_q - SW'(1);
          state_d    = (cnt_q == SW'(1)) ? S_DONE : S_PLOT;
        end
      end
      S_MOD: begin
        // read data arrives now; set the bit and write back
        ram_we    = 1'b1;
        ram_waddr = pix_addr_q;
        ram_wdata = ram_rdata | (ROWS'(1) << pix_row_q);
        px_d      = px_q + ax_q;
        py_d      = py_q + ay_q;
        cnt_d     = cnt_q - SW'(1);
        state_d   = (cnt_q == SW'(1)) ? S_DONE : S_PLOT;
      end
      S_RDCOL: begin
        res_bits_d = rd_ext[dlr_pkg::WORD_W-1:0];
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_bits_d  = res_bits_q;
          out_clip_d  = res_clip_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sweep_clr_q <= 1'b0;
      sw_q        <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      dcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      sweep_clr_q <= sweep_clr_d;
      sw_q        <= sw_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      dcnt_q      <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q       <= px_d;
    py_q       <= py_d;
    ax_q       <= ax_d;
    ay_q       <= ay_d;
    steps_q    <= steps_d;
    ady_q      <= ady_d;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    num_q      <= num_d;
    rem_q      <= rem_d;
    pix_addr_q <= pix_addr_d;
    pix_row_q  <= pix_row_d;
    res_bits_q <= res_bits_d;
    res_clip_q <= res_clip_d;
    out_bits_q <= out_bits_d;
    out_clip_q <= out_clip_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_bits_o = out_bits_q;
  assign clipped_o   = out_clip_q;

  a_mod_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOD |-> $past(state_q) == S_PLOT && $past(ram_re))
    else $error("read-modify-write without a preceding read");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVX || state_q == S_DIVY) |-> rem_q < steps_q)
    else $error("divider remainder not below divisor");

  a_plot_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PLOT || state_q == S_MOD) |-> cnt_q != '0)
    else $error("plot loop running with zero count");

  a_read_not_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (read_bits_o != '0) |-> !clipped_o)
    else $error("column data returned on a clipped request");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWEEP |-> !in_ready_o && !ram_re)
    else $error("request taken or read issued during zeroing sweep");

endmodule

[sim/dda_line_raster_bitplane_test.sv]
// Testbench for the DDA line rasterizer: directed table, random requests, scoreboard.
module dda_line_raster_bitplane_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CMD_W        = dlr_pkg::CMD_W;
  localparam int unsigned COORD_W      = dlr_pkg::COORD_W;
  localparam int unsigned COL_IDX_W    = dlr_pkg::COL_IDX_W;
  localparam int unsigned WORD_W       = dlr_pkg::WORD_W;
  localparam int unsigned COLUMNS      = 128;
  localparam int unsigned ROWS         = 32;
  localparam int unsigned FRAC_BITS    = 8;
  localparam longint      FRAC_ONE     = longint'(1) << FRAC_BITS;
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
  localparam int unsigned PHASE_ITEMS  = 250;
  localparam int unsigned HOLD_CYCLES  = 2500;
  localparam int unsigned DRAIN_CYCLES = 1200;
  localparam int unsigned STALL_LIMIT  = 20000;

  typedef struct {
    logic [CMD_W-1:0]          cmd;
    logic signed [COORD_W-1:0] xs;
    logic signed [COORD_W-1:0] ys;
    logic signed [COORD_W-1:0] xe;
    logic signed [COORD_W-1:0] ye;
    logic [COL_IDX_W-1:0]      col;
    logic [WORD_W-1:0]         bits;
    bit                        typed;
    logic [WORD_W-1:0]         exp_bits;
    logic                      exp_clip;
  } raster_req_t;

  typedef struct {
    logic [WORD_W-1:0] read_bits;
    logic              clipped;
  } raster_rsp_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [CMD_W-1:0]          command_i;
  logic signed [COORD_W-1:0] x_start_i;
  logic signed [COORD_W-1:0] y_start_i;
  logic signed [COORD_W-1:0] x_end_i;
  logic signed [COORD_W-1:0] y_end_i;
  logic [COL_IDX_W-1:0]      column_index_i;
  logic [WORD_W-1:0]         column_bits_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [WORD_W-1:0]         read_bits_o;
  logic                      clipped_o;

  dda_line_raster_bitplane #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .x_start_i     (x_start_i),
    .y_start_i     (y_start_i),
    .x_end_i       (x_end_i),
    .y_end_i       (y_end_i),
    .column_index_i(column_index_i),
    .column_bits_i (column_bits_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_bits_o   (read_bits_o),
    .clipped_o     (clipped_o)
  );

  logic [ROWS-1:0] plane [COLUMNS] = '{default: '0};
  raster_req_t     directed_q [$];
  raster_rsp_t     pending_rsp_q [$];
  raster_req_t     offered;
  int unsigned     idle_pct;
  int unsigned     stall_pct;
  int unsigned     hold_req;
  int unsigned     errors;
  int unsigned     accepted;
  int unsigned     checked;
  int unsigned     lines_drawn;
  int unsigned     clipped_seen;
  int unsigned     quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Set one pixel of the expected plane; report whether it fell off screen.
  function automatic logic set_pixel(longint x, longint y);
    if (x < 0 || x >= longint'(COLUMNS) || y < 0 || y >= longint'(ROWS)) return 1'b1;
    plane[x][y] = 1'b1;
    return 1'b0;
  endfunction

  function automatic logic draw_segment(longint x0, longint y0, longint x1, longint y1);
    longint dx, dy, adx, ady, steps, ax, ay, px, py;
    logic   clip;
    dx    = x1 - x0;
    dy    = y1 - y0;
    adx   = dx < 0 ? -dx : dx;
    ady   = dy < 0 ? -dy : dy;
    steps = adx > ady ? adx : ady;
    clip  = 1'b0;
    if (steps == 0) return 1'b0;
    // increments truncate toward zero, plotted coordinates floor
    ax = (dx * FRAC_ONE) / steps;
    ay = (dy * FRAC_ONE) / steps;
    px = x0 * FRAC_ONE;
    py = y0 * FRAC_ONE;
    for (longint i = 0; i < steps; i++) begin
      clip |= set_pixel(px >>> FRAC_BITS, py >>> FRAC_BITS);
      px += ax;
      py += ay;
    end
    return clip;
  endfunction

  function automatic raster_rsp_t predict_response(raster_req_t r);
    raster_rsp_t rsp;
    rsp.read_bits = '0;
    rsp.clipped   = 1'b0;
    case (r.cmd)
      dlr_pkg::CMD_CLEAR: foreach (plane[i]) plane[i] = '0;
      dlr_pkg::CMD_PIXEL: rsp.clipped = set_pixel(r.xs, r.ys);
      dlr_pkg::CMD_LINE:  rsp.clipped = draw_segment(r.xs, r.ys, r.xe, r.ye);
      dlr_pkg::CMD_WRCOL: begin
        if (r.col < COLUMNS) plane[r.col] = r.bits[ROWS-1:0];
        else rsp.clipped = 1'b1;
      end
      dlr_pkg::CMD_RDCOL: begin
        if (r.col < COLUMNS) rsp.read_bits = WORD_W'(plane[r.col]);
        else rsp.clipped = 1'b1;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic add_row(logic [CMD_W-1:0] cmd, int xs, int ys, int xe, int ye, int col,
                         logic [WORD_W-1:0] bits, bit typed, logic [WORD_W-1:0] eb,
                         logic ec);
    raster_req_t r;
    r.cmd      = cmd;
    r.xs       = COORD_W'(xs);
    r.ys       = COORD_W'(ys);
    r.xe       = COORD_W'(xe);
    r.ye       = COORD_W'(ye);
    r.col      = COL_IDX_W'(col);
    r.bits     = bits;
    r.typed    = typed;
    r.exp_bits = eb;
    r.exp_clip = ec;
    directed_q.push_back(r);
  endtask

  // Mostly near the screen, now and then anywhere in the 9-bit range.
  function automatic logic signed [COORD_W-1:0] rand_coord(int lo, int hi);
    if ($urandom_range(9) < 7) return COORD_W'($urandom_range(hi - lo) + lo);
    return COORD_W'($urandom);
  endfunction

  function automatic raster_req_t random_request();
    raster_req_t r;
    int unsigned pick;
    pick       = $urandom_range(99);
    r.typed    = 1'b0;
    r.exp_bits = '0;
    r.exp_clip = 1'b0;
    r.xs       = rand_coord(-20, 147);
    r.ys       = rand_coord(-12, 43);
    r.xe       = rand_coord(-20, 147);
    r.ye       = rand_coord(-12, 43);
    r.col      = COL_IDX_W'($urandom);
    r.bits     = $urandom;
    if (pick < 4) r.cmd = dlr_pkg::CMD_CLEAR;
    else if (pick < 30) r.cmd = dlr_pkg::CMD_PIXEL;
    else if (pick < 65) begin
      r.cmd = dlr_pkg::CMD_LINE;
      if ($urandom_range(19) == 0) begin
        r.xe = r.xs;
        r.ye = r.ys;
      end
    end
    else if (pick < 77) r.cmd = dlr_pkg::CMD_WRCOL;
    else if (pick < 95) r.cmd = dlr_pkg::CMD_RDCOL;
    else r.cmd = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
    return r;
  endfunction

  // Enter and leave at a falling edge; hold the request until it is taken.
  task automatic send_request(raster_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    offered        = r;
    command_i      = r.cmd;
    x_start_i      = r.xs;
    y_start_i      = r.ys;
    x_end_i        = r.xe;
    y_end_i        = r.ye;
    column_index_i = r.col;
    column_bits_i  = r.bits;
    in_valid_i     = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    raster_rsp_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_rsp_q.size() == 0) begin
          $error("response with no request pending: read_bits %h clipped %b",
                 read_bits_o, clipped_o);
          errors++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (read_bits_o !== want.read_bits) begin
            $error("read_bits: expected %h, got %h", want.read_bits, read_bits_o);
            errors++;
          end
          if (clipped_o !== want.clipped) begin
            $error("clipped: expected %b, got %b", want.clipped, clipped_o);
            errors++;
          end
          checked++;
          if (clipped_o === 1'b1) clipped_seen++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = predict_response(offered);
        if (offered.typed) begin
          want.read_bits = offered.exp_bits;
          want.clipped   = offered.exp_clip;
        end
        pending_rsp_q.push_back(want);
        accepted++;
        if (offered.cmd == dlr_pkg::CMD_LINE) lines_drawn++;
      end
    end
  end

  // Drop the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left   = 0;
    hold_seen   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int unsigned phase_idle  [4] = '{0, 76, 0, 31};
    int unsigned phase_stall [4] = '{0, 0, 76, 31};
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = dlr_pkg::CMD_CLEAR;
    x_start_i      = '0;
    y_start_i      = '0;
    x_end_i        = '0;
    y_end_i        = '0;
    column_index_i = '0;
    column_bits_i  = '0;
    idle_pct       = 0;
    stall_pct      = 0;
    hold_req       = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    //      command             xs    ys   xe   ye  col  bits     typed exp bits     clip
    add_row(dlr_pkg::CMD_RDCOL,    0,    0,   0,   0,   0, '0,           1, '0,           1'b0);
    add_row(dlr_pkg::CMD_RDCOL,    0,    0,   0,   0, 127, '0,           1, '0,           1'b0);
    add_row(dlr_pkg::CMD_WRCOL,    0,    0,   0,   0,   5, 32'hFFFFFFFF, 1, '0,           1'b0);
    add_row(dlr_pkg::CMD_RDCOL,    0,    0,   0,   0,   5, '0,           1, 32'hFFFFFFFF, 1'b0);
    add_row(dlr_pkg::CMD_CLEAR,    0,    0,   0,   0,   0, '0,           1, '0,           1'b0);
    add_row(dlr_pkg::CMD_RDCOL,    0,    0,   0,   0,   5, '0,           1, '0,           1'b0);
    add_row(dlr_pkg::CMD_PIXEL,    0,    0,   0,   0,   0, '0,           1, '0,           1'b0);
    add_row(dlr_pkg::CMD_PIXEL,  127,   31,   0,   0,   0, '0,           1, '0,           1'b0);
    add_row(dlr_pkg::CMD_PIXEL, -256, -256,   0,   0,   0, '0,           1, '0,           1'b1);
    add_row(dlr_pkg::CMD_PIXEL,  255,  255,   0,   0,   0, '0,           1, '0,           1'b1);
    add_row(dlr_pkg::CMD_PIXEL,  128,    0,   0,   0,   0, '0,           1, '0,           1'b1);
    add_row(dlr_pkg::CMD_PIXEL,    0,   32,   0,   0,   0, '0,           1, '0,           1'b1);
    add_row(dlr_pkg::CMD_RDCOL,    0,    0,   0,   0,   0, '0,           1, 32'h00000001, 1'b0);
    add_row(dlr_pkg::CMD_RDCOL,    0,    0,   0,   0, 127, '0,           1, 32'h80000000, 1'b0);
    add_row(dlr_pkg::CMD_LINE,    10,   10,  10,  10,   0, '0,           1, '0,           1'b0);
    add_row(dlr_pkg::CMD_LINE,     0,    0, 127,  31,   0, '0,           0, '0,           1'b0);
    add_row(dlr_pkg::CMD_LINE,  -256, -256, 255, 255,   0, '0,           0, '0,           1'b0);
    add_row(dlr_pkg::CMD_LINE,   255,    0,-256,  31,   0, '0,           0, '0,           1'b0);
    add_row(dlr_pkg::CMD_LINE,     3,   31,   5,  -1,   0, '0,           0, '0,           1'b0);
    add_row(dlr_pkg::CMD_RDCOL,    0,    0,   0,   0,  64, '0,           0, '0,           1'b0);
    add_row(CMD_SPARE_FIRST,       0,    0,   0,   0,   0, '0,           1, '0,           1'b0);
    add_row(CMD_SPARE_LAST,        0,    0,   0,   0,   0, '0,           1, '0,           1'b0);
    add_row(dlr_pkg::CMD_WRCOL,    0,    0,   0,   0,   9, 32'h12345678, 1, '0,           1'b0);
    add_row(dlr_pkg::CMD_RDCOL,    0,    0,   0,   0,   9, '0,           1, 32'h12345678, 1'b0);
    add_row(dlr_pkg::CMD_CLEAR,    0,    0,   0,   0,   0, '0,           1, '0,           1'b0);
    foreach (directed_q[i]) send_request(directed_q[i]);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      // hold the output off while requests keep coming
      if (p == 0) hold_req++;
      for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
    end
    in_valid_i = 1'b0;
    stall_pct  = 0;

    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_rsp_q.size() != 0) begin
      $error("%0d responses never arrived", pending_rsp_q.size());
    end

    $display("tb: %0d requests, %0d responses checked, %0d line draws, %0d clipped",
             accepted, checked, lines_drawn, clipped_seen);
    $display("tb: phases run: free flow with output hold-off, sender gaps, receiver stalls, both");
    if (errors == 0 && pending_rsp_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
